FILE: rtl/core/all_pairs_shortest_path_unit_defines.svh
// ---------------------------------------------------------------------------
// All-pairs shortest path unit: assertion macros
// Shared macros for the concurrent checks of the shortest path unit.
// ---------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_UNIT_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define APSP_ASSERT(lbl, clock, rstn, prop, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) prop) else $error(msg);

// Property that must never hold outside reset.
`define APSP_NEVER(lbl, clock, rstn, prop, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) not (prop)) else $error(msg);

`endif

FILE: rtl/core/apsp_pkg.sv
// ---------------------------------------------------------------------------
// Shortest path package
// Distance type, request codes, saturating path arithmetic and cell control.
// ---------------------------------------------------------------------------
package apsp_pkg;

	localparam int DIST_W = 20;

	// Bit DIST_W is the infinite flag, the bits below it the distance.
	typedef logic [DIST_W:0] dist_t;

	localparam dist_t INF_VAL      = {1'b1, {DIST_W{1'b0}}};
	localparam dist_t DIST_MAX_VAL = {1'b0, {DIST_W{1'b1}}};

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_RUN  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	typedef struct packed {
		logic  shift;
		logic  relax;
		logic  capture;
		logic  load;
		dist_t ld_val;
	} cell_ctrl_t;

	// Infinity absorbs, a finite sum saturates.
	function automatic dist_t path_sum(dist_t a, dist_t b);
		logic [DIST_W:0] s;
		s = {1'b0, a[DIST_W-1:0]} + {1'b0, b[DIST_W-1:0]};
		if (a[DIST_W] || b[DIST_W])
			return INF_VAL;
		if (s[DIST_W])
			return DIST_MAX_VAL;
		return {1'b0, s[DIST_W-1:0]};
	endfunction

	// True when the candidate is strictly shorter than the current entry.
	function automatic logic shorter(dist_t cand, dist_t cur);
		if (cand[DIST_W])
			return 1'b0;
		if (cur[DIST_W])
			return 1'b1;
		return cand[DIST_W-1:0] < cur[DIST_W-1:0];
	endfunction

endpackage

FILE: rtl/core/apsp_cell.sv
// ---------------------------------------------------------------------------
// Shortest path column cell
// Holds one matrix column as a rotating line and relaxes its head entry.
// ---------------------------------------------------------------------------
module apsp_cell #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  apsp_pkg::cell_ctrl_t ctrl,
	input  logic                col_ok,
	input  logic                sel,
	input  apsp_pkg::dist_t     dik,
	output apsp_pkg::dist_t     head
);
	import apsp_pkg::*;

	dist_t line_q [DEPTH];
	dist_t rowk_q;
	dist_t via;
	dist_t nxt;

	assign head = line_q[0];

	always_comb begin
		via = path_sum(dik, rowk_q);
		nxt = (ctrl.relax && col_ok && shorter(via, line_q[0])) ? via : line_q[0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int d = 0; d < DEPTH - 1; d++)
				line_q[d] <= line_q[d+1];
			line_q[DEPTH-1] <= nxt;
		end else if (ctrl.load && sel) begin
			line_q[0] <= ctrl.ld_val;
		end
		if (ctrl.capture)
			rowk_q <= line_q[0];
	end

endmodule

FILE: rtl/core/all_pairs_shortest_path_unit.sv
// ---------------------------------------------------------------------------
// All-pairs shortest path unit
// Floyd-Warshall over a row of column cells whose lines rotate in step.
// ---------------------------------------------------------------------------
//  channel   signals                                   direction
//  request   in_valid in_stall op src dst weight no_edge   in
//  result    out_valid out_stall out_src out_dst distance unreachable   out
//  config    cfg_wen cfg_wdata (node_count)             in
//
// A load or a read rotates the matrix until row src sits at the head of the
// cells and then acts; an out-of-range request acts without rotating.
// A run seeks row k to the head for each vertex below node_count and then
// sweeps one full rotation of the lines, both paced by the shared rotation.
// Reset clears control and sets node_count to 16; the matrix is not cleared.
// A read waits at the head while a previous result is still stalled.
// ---------------------------------------------------------------------------
module all_pairs_shortest_path_unit #(
	parameter int MAX_NODES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [3:0]  src,
	input  logic [3:0]  dst,
	input  logic [15:0] weight,
	input  logic        no_edge,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  out_src,
	output logic [3:0]  out_dst,
	output logic [19:0] distance,
	output logic        unreachable
);
	import apsp_pkg::*;

	localparam int IW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
	localparam int CW = (IW > 4) ? IW : 4;
	localparam logic [7:0] MAXN8 = 8'(MAX_NODES);
	localparam logic [IW-1:0] LAST = IW'(MAX_NODES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEEK,
		ST_RSEEK,
		ST_SWEEP
	} state_t;

	state_t        state_q;
	logic [4:0]    node_count_q;
	logic [IW-1:0] hd_q;
	logic [IW-1:0] k_q;
	logic [IW-1:0] cnt_q;
	logic [1:0]    op_q;
	logic [3:0]    src_q;
	logic [3:0]    dst_q;
	logic [15:0]   wt_q;
	logic          ne_q;
	logic          inside_q;
	logic          out_valid_q;
	logic [3:0]    out_src_q;
	logic [3:0]    out_dst_q;
	logic [19:0]   distance_q;
	logic          unreachable_q;

	logic          accept;
	logic          in_range;
	logic [7:0]    neff8;
	logic          match;
	logic          at_k;
	logic          out_free;
	logic          rd_done;
	cell_ctrl_t    ctrl;
	dist_t         heads [MAX_NODES];
	dist_t         dik;
	dist_t         rd_val;
	logic [MAX_NODES-1:0] col_ok;
	logic [MAX_NODES-1:0] sel;

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign in_range    = ({4'b0, src} < MAXN8) && ({4'b0, dst} < MAXN8);
	assign neff8       = (8'(node_count_q) > MAXN8) ? MAXN8 : 8'(node_count_q);
	assign match       = !inside_q || (CW'(hd_q) == CW'(src_q));
	assign at_k        = (hd_q == k_q);
	assign out_free    = !out_valid_q || !out_stall;
	assign rd_done     = (state_q == ST_SEEK) && match && (op_q == OP_READ) && out_free;
	assign dik         = heads[k_q];
	assign rd_val      = heads[IW'(dst_q)];

	assign out_valid   = out_valid_q;
	assign out_src     = out_src_q;
	assign out_dst     = out_dst_q;
	assign distance    = distance_q;
	assign unreachable = unreachable_q;

	// The cells rotate together while seeking a row and during a sweep;
	// relaxation only touches rows and columns below node_count.
	always_comb begin
		ctrl.shift   = ((state_q == ST_SEEK) && !match) ||
		               ((state_q == ST_RSEEK) && !at_k) ||
		               (state_q == ST_SWEEP);
		ctrl.relax   = (state_q == ST_SWEEP) && (8'(hd_q) < neff8);
		ctrl.capture = (state_q == ST_RSEEK) && at_k;
		ctrl.load    = (state_q == ST_SEEK) && match && inside_q && (op_q == OP_LOAD);
		ctrl.ld_val  = ne_q ? INF_VAL : {{(DIST_W - 15){1'b0}}, wt_q};
	end

	for (genvar j = 0; j < MAX_NODES; j++) begin : g_cell
		assign col_ok[j] = (8'(j) < neff8);
		assign sel[j]    = (IW'(dst_q) == IW'(j));
		apsp_cell #(
			.DEPTH(MAX_NODES)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.col_ok(col_ok[j]),
			.sel   (sel[j]),
			.dik   (dik),
			.head  (heads[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= 5'd16;
			hd_q         <= '0;
			k_q          <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen)
				node_count_q <= cfg_wdata;
			// A new result replaces one that leaves in the same cycle.
			out_valid_q <= rd_done || (out_valid_q && out_stall);
			if (ctrl.shift)
				hd_q <= (hd_q == LAST) ? '0 : hd_q + 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_LOAD, OP_READ: state_q <= ST_SEEK;
							OP_RUN: begin
								k_q <= '0;
								if (neff8 != 8'd0)
									state_q <= ST_RSEEK;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SEEK: begin
					if (match) begin
						if (op_q == OP_LOAD) begin
							state_q <= ST_IDLE;
						end else if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RSEEK: begin
					if (at_k) begin
						cnt_q   <= '0;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						if (8'(k_q) == neff8 - 8'd1) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_RSEEK;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			src_q    <= src;
			dst_q    <= dst;
			wt_q     <= weight;
			ne_q     <= no_edge;
			inside_q <= in_range;
		end
		if (rd_done) begin
			out_src_q <= src_q;
			out_dst_q <= dst_q;
			if (!inside_q || rd_val[DIST_W]) begin
				distance_q    <= '0;
				unreachable_q <= 1'b1;
			end else begin
				distance_q    <= rd_val[DIST_W-1:0];
				unreachable_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/apsp_checker.sv
// ---------------------------------------------------------------------------
// Shortest path unit checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "all_pairs_shortest_path_unit_defines.svh"

module apsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [19:0] distance,
	input logic        unreachable
);

	// A stalled result stays and holds its distance.
	`APSP_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(distance), "stalled result changed")

	// An unreachable result carries a zero distance.
	`APSP_NEVER(a_unreach_zero, clk, arst_n, out_valid && unreachable && (distance != 20'd0), "unreachable result with nonzero distance")

	// A result only appears while a read request is being served.
	`APSP_ASSERT(a_out_busy, clk, arst_n, $rose(out_valid) |-> $past(in_stall), "result appeared without a pending read")

endmodule

bind all_pairs_shortest_path_unit apsp_checker u_apsp_checker (.*);
